### src/cgs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Conjugate gradient solver package
// Shared constants, codes and control structures of the solver.
// ----------------------------------------------------------------------------
package cgs_pkg;

	localparam int MAX_SIZE  = 16;
	localparam int FRAC_BITS = 16;
	localparam int OUT_CAP   = (MAX_SIZE < 16) ? MAX_SIZE : 16;
	localparam int IDX_W     = $clog2(MAX_SIZE);
	localparam int N_W       = 5;
	localparam int CNT_W     = (IDX_W > N_W) ? IDX_W : N_W;
	localparam int MADDR_W   = $clog2(MAX_SIZE * MAX_SIZE);
	localparam int LC_W      = 8;
	localparam int DIV_STEPS = 32;

	localparam logic signed [31:0] ONE_Q = 32'(1) << FRAC_BITS;

	localparam logic [1:0] KIND_MAT   = 2'd0;
	localparam logic [1:0] KIND_RHS   = 2'd1;
	localparam logic [1:0] KIND_GUESS = 2'd2;
	localparam logic [1:0] KIND_NONE  = 2'd3;

	localparam logic [1:0] CFG_SIZE  = 2'd0;
	localparam logic [1:0] CFG_LIMIT = 2'd1;
	localparam logic [1:0] CFG_ITER  = 2'd2;

	localparam logic [1:0] MODE_MV   = 2'd0;
	localparam logic [1:0] MODE_DOT  = 2'd1;
	localparam logic [1:0] MODE_AXPY = 2'd2;
	localparam logic [1:0] MODE_OUT  = 2'd3;

	localparam logic [2:0] VEC_X = 3'd0;
	localparam logic [2:0] VEC_B = 3'd1;
	localparam logic [2:0] VEC_R = 3'd2;
	localparam logic [2:0] VEC_P = 3'd3;
	localparam logic [2:0] VEC_Q = 3'd4;

	typedef struct packed {
		logic [1:0]         mode;
		logic [2:0]         src_a;
		logic [2:0]         src_b;
		logic [2:0]         dst;
		logic               sub;
		logic signed [31:0] coef;
	} cgs_cmd_t;

	typedef struct packed {
		logic               we;
		logic [1:0]         kind;
		logic [MADDR_W-1:0] maddr;
		logic [IDX_W-1:0]   vaddr;
		logic signed [31:0] data;
	} cgs_load_t;

endpackage

### src/cgs_qdiv.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fixed-point quotient unit
// Restoring divider giving (num << FRAC_BITS) / den, truncated and saturated.
// ----------------------------------------------------------------------------
module cgs_qdiv (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               go,
	input  logic signed [63:0] num,
	input  logic signed [63:0] den,
	output logic               done,
	output logic signed [31:0] quo
);
	import cgs_pkg::*;

	logic        busy_q, fin_q, neg_q, sat_q;
	logic [5:0]  cnt_q;
	logic [63:0] ud_q, rem_q;
	logic [31:0] low_q, q_q;
	logic [63:0] un, ud, un_sh;
	logic [64:0] rem_sh;
	logic        ge;

	assign un     = num[63] ? 64'(-num) : 64'(num);
	assign ud     = den[63] ? 64'(-den) : 64'(den);
	assign un_sh  = un << FRAC_BITS;
	assign rem_sh = {rem_q, low_q[31]};
	assign ge     = rem_sh >= {1'b0, ud_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
		end else if (go) begin
			neg_q <= num[63] ^ den[63];
			ud_q  <= ud;
			q_q   <= '0;
			if ((un >> (32 - FRAC_BITS)) >= ud) begin
				sat_q  <= 1'b1;
				busy_q <= 1'b0;
				fin_q  <= 1'b1;
			end else begin
				sat_q  <= 1'b0;
				busy_q <= 1'b1;
				fin_q  <= 1'b0;
				cnt_q  <= 6'(DIV_STEPS);
				rem_q  <= un >> (32 - FRAC_BITS);
				low_q  <= un_sh[31:0];
			end
		end else if (busy_q) begin
			rem_q <= ge ? 64'(rem_sh - {1'b0, ud_q}) : rem_sh[63:0];
			q_q   <= {q_q[30:0], ge};
			low_q <= low_q << 1;
			cnt_q <= cnt_q - 6'd1;
			if (cnt_q == 6'd1) begin
				busy_q <= 1'b0;
				fin_q  <= 1'b1;
			end
		end else begin
			fin_q <= 1'b0;
		end
	end

	assign done = fin_q;

	always_comb begin
		if (sat_q || q_q[31]) quo = neg_q ? 32'sh80000000 : 32'sh7fffffff;
		else                  quo = neg_q ? -$signed(q_q) : $signed(q_q);
	end

endmodule

### src/cgs_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Conjugate gradient vector engine
// Stores and one shared multiply-accumulate pipeline running one pass at a time.
// ----------------------------------------------------------------------------
module cgs_engine (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    go,
	input  cgs_pkg::cgs_cmd_t       cmd,
	input  logic [cgs_pkg::N_W-1:0] n,
	input  cgs_pkg::cgs_load_t      ld,
	output logic                    done,
	output logic signed [63:0]      dot_res,
	output logic                    out_valid,
	output logic signed [31:0]      out_data,
	output logic [3:0]              out_pos,
	output logic                    out_last
);
	import cgs_pkg::*;

	logic signed [31:0] mem_m [MAX_SIZE*MAX_SIZE];
	logic signed [31:0] mem_x [MAX_SIZE];
	logic signed [31:0] mem_b [MAX_SIZE];
	logic signed [31:0] mem_r [MAX_SIZE];
	logic signed [31:0] mem_p [MAX_SIZE];
	logic signed [31:0] mem_q [MAX_SIZE];
	logic signed [31:0] rd_m, rd_x, rd_b, rd_r, rd_p, rd_q;

	cgs_cmd_t           cmd_q;
	logic               run_q, issue_q;
	logic [CNT_W-1:0]   i_q, j_q, n_m1;
	logic               is_mv, row_end, pass_end;
	logic [IDX_W-1:0]   vaddr;
	logic [MADDR_W-1:0] maddr;

	logic               v_s1, rowend_s1, last_s1;
	logic [CNT_W-1:0]   widx_s1;
	logic               v_s2, rowend_s2;
	logic [CNT_W-1:0]   widx_s2;
	logic signed [63:0] prod_s2;
	logic signed [31:0] base_s2;
	logic signed [63:0] acc_q;

	logic signed [31:0] vec_a, vec_b, opa;
	logic signed [64:0] sum;
	logic signed [63:0] acc_next, acc_sh, t, axv, wide;
	logic signed [31:0] wval;
	logic               wr_s2;

	assign n_m1     = CNT_W'(n) - CNT_W'(1);
	assign is_mv    = cmd_q.mode == MODE_MV;
	assign row_end  = j_q == n_m1;
	assign pass_end = row_end && (!is_mv || i_q == n_m1);
	assign vaddr    = j_q[IDX_W-1:0];
	assign maddr    = MADDR_W'(MADDR_W'(i_q) * MADDR_W'(MAX_SIZE) + MADDR_W'(j_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q   <= 1'b0;
			issue_q <= 1'b0;
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
		end else begin
			v_s1 <= issue_q;
			v_s2 <= v_s1;
			if (go) begin
				cmd_q   <= cmd;
				run_q   <= 1'b1;
				issue_q <= 1'b1;
				i_q     <= '0;
				j_q     <= '0;
			end else begin
				if (issue_q) begin
					if (row_end) begin
						j_q <= '0;
						i_q <= i_q + CNT_W'(1);
						if (pass_end) issue_q <= 1'b0;
					end else begin
						j_q <= j_q + CNT_W'(1);
					end
				end
				if (done) run_q <= 1'b0;
			end
		end
	end

	assign done = run_q && !issue_q && !v_s1 && !v_s2;

	always_ff @(posedge clk) begin
		if (ld.we && ld.kind == KIND_MAT) mem_m[ld.maddr] <= ld.data;
		rd_m <= mem_m[maddr];
	end

	always_ff @(posedge clk) begin
		if (ld.we && ld.kind == KIND_GUESS) mem_x[ld.vaddr] <= ld.data;
		else if (wr_s2 && cmd_q.dst == VEC_X) mem_x[widx_s2[IDX_W-1:0]] <= wval;
		rd_x <= mem_x[vaddr];
	end

	always_ff @(posedge clk) begin
		if (ld.we && ld.kind == KIND_RHS) mem_b[ld.vaddr] <= ld.data;
		rd_b <= mem_b[vaddr];
	end

	always_ff @(posedge clk) begin
		if (wr_s2 && cmd_q.dst == VEC_R) mem_r[widx_s2[IDX_W-1:0]] <= wval;
		rd_r <= mem_r[vaddr];
	end

	always_ff @(posedge clk) begin
		if (wr_s2 && cmd_q.dst == VEC_P) mem_p[widx_s2[IDX_W-1:0]] <= wval;
		rd_p <= mem_p[vaddr];
	end

	always_ff @(posedge clk) begin
		if (wr_s2 && cmd_q.dst == VEC_Q) mem_q[widx_s2[IDX_W-1:0]] <= wval;
		rd_q <= mem_q[vaddr];
	end

	always_comb begin
		unique case (cmd_q.src_a)
			VEC_X:   vec_a = rd_x;
			VEC_B:   vec_a = rd_b;
			VEC_R:   vec_a = rd_r;
			VEC_P:   vec_a = rd_p;
			default: vec_a = rd_q;
		endcase
		unique case (cmd_q.src_b)
			VEC_X:   vec_b = rd_x;
			VEC_B:   vec_b = rd_b;
			VEC_R:   vec_b = rd_r;
			VEC_P:   vec_b = rd_p;
			default: vec_b = rd_q;
		endcase
		if (is_mv)                         opa = rd_m;
		else if (cmd_q.mode == MODE_AXPY) opa = cmd_q.coef;
		else                               opa = vec_a;
	end

	always_ff @(posedge clk) begin
		rowend_s1 <= row_end;
		last_s1   <= pass_end;
		widx_s1   <= is_mv ? i_q : j_q;
		prod_s2   <= opa * vec_b;
		base_s2   <= vec_a;
		rowend_s2 <= rowend_s1;
		widx_s2   <= widx_s1;
	end

	always_comb begin
		sum = {acc_q[63], acc_q} + {prod_s2[63], prod_s2};
		if (sum[64] != sum[63]) acc_next = sum[64] ? 64'sh8000000000000000 : 64'sh7fffffffffffffff;
		else                    acc_next = sum[63:0];
		acc_sh = acc_next >>> FRAC_BITS;
		t      = prod_s2 >>> FRAC_BITS;
		axv    = cmd_q.sub ? (64'(base_s2) - t) : (64'(base_s2) + t);
		wide   = is_mv ? acc_sh : axv;
		if (wide > 64'sd2147483647)       wval = 32'sh7fffffff;
		else if (wide < -64'sd2147483648) wval = 32'sh80000000;
		else                              wval = wide[31:0];
		wr_s2 = v_s2 && (cmd_q.mode == MODE_AXPY || (is_mv && rowend_s2));
	end

	always_ff @(posedge clk) begin
		if (go) acc_q <= '0;
		else if (v_s2 && (is_mv || cmd_q.mode == MODE_DOT))
			acc_q <= (is_mv && rowend_s2) ? 64'sd0 : acc_next;
	end

	assign dot_res   = acc_q >>> FRAC_BITS;
	assign out_valid = v_s1 && cmd_q.mode == MODE_OUT;
	assign out_data  = rd_x;
	assign out_pos   = widx_s1[3:0];
	assign out_last  = last_s1;

endmodule

### src/conjugate_gradient_solver.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Conjugate gradient solver
// Dense fixed-point conjugate gradient solve with load, solve and emit phases.
// ----------------------------------------------------------------------------
// Channel   Handshake               Payload
// input     start, busy             kind, value, last
// result    strobe                  solution, position, converged, final_res
// config    cfg_valid, cfg_ready    cfg_index, cfg_data
//
// Load items transfer one per cycle while busy is low. The item that ends
// the guess starts a solve that runs matrix-vector, dot product and update
// passes one at a time through the single multiply-accumulate pipeline,
// with divides that end early when a quotient saturates, then n results on
// consecutive cycles. A size write walks the load row and column up to the
// load position under the new size. Results cannot be stalled. Reset clears
// the sequencer and sets the config registers to their defaults.
// ----------------------------------------------------------------------------
module conjugate_gradient_solver (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         kind,
	input  logic signed [31:0] value,
	input  logic               last,
	output logic               strobe,
	output logic signed [31:0] solution,
	output logic [3:0]         position,
	output logic               converged,
	output logic               final_res,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [31:0]        cfg_data
);
	import cgs_pkg::*;

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_REMAP = 4'd1;
	localparam logic [3:0] S_MV0   = 4'd2;
	localparam logic [3:0] S_INITR = 4'd3;
	localparam logic [3:0] S_INITP = 4'd4;
	localparam logic [3:0] S_RS0   = 4'd5;
	localparam logic [3:0] S_MVP   = 4'd6;
	localparam logic [3:0] S_DEN   = 4'd7;
	localparam logic [3:0] S_ALPHA = 4'd8;
	localparam logic [3:0] S_UPX   = 4'd9;
	localparam logic [3:0] S_UPR   = 4'd10;
	localparam logic [3:0] S_RSN   = 4'd11;
	localparam logic [3:0] S_BETA  = 4'd12;
	localparam logic [3:0] S_UPP   = 4'd13;
	localparam logic [3:0] S_EMIT  = 4'd14;

	logic [3:0]         state_q;
	logic               launched_q, conv_q;
	logic signed [63:0] rs_q, rsn_q, den_q;
	logic signed [31:0] alpha_q, beta_q;
	logic [9:0]         it_q;
	logic [LC_W-1:0]    lc_q, row_q, col_q, k_q;
	logic [1:0]         prev_kind_q;
	logic [4:0]         size_q;
	logic [31:0]        limit_q;
	logic [9:0]         iter_q;

	logic [N_W-1:0]     n_eff;
	logic [9:0]         n_sq, count;
	logic               accept, same, wrap;
	logic [LC_W-1:0]    eff_lc, eff_row, eff_col;
	logic               pass_st, go, eng_done, div_go, div_done;
	cgs_cmd_t           cmd;
	cgs_load_t          ld;
	logic signed [63:0] dot_res, div_num, div_den;
	logic signed [31:0] quo;

	always_comb begin
		if (size_q == 5'd0)                 n_eff = 5'd1;
		else if (32'(size_q) > OUT_CAP)     n_eff = N_W'(OUT_CAP);
		else                                n_eff = size_q;
		n_sq   = 10'(n_eff) * 10'(n_eff);
		count  = (kind == KIND_MAT) ? n_sq : 10'(n_eff);
		accept = start && !busy;
		same   = (kind == prev_kind_q) && (10'(lc_q) < count);
		eff_lc  = same ? lc_q : '0;
		eff_row = same ? row_q : '0;
		eff_col = same ? col_q : '0;
		wrap   = (10'(eff_lc) + 10'd1) >= count;
		ld.we    = accept && kind != KIND_NONE;
		ld.kind  = kind;
		ld.maddr = MADDR_W'(MADDR_W'(eff_row) * MADDR_W'(MAX_SIZE) + MADDR_W'(eff_col));
		ld.vaddr = eff_lc[IDX_W-1:0];
		ld.data  = value;
	end

	always_comb begin
		cmd     = '0;
		pass_st = 1'b1;
		unique case (state_q)
			S_MV0:   begin cmd.mode = MODE_MV; cmd.src_b = VEC_X; cmd.dst = VEC_Q; end
			S_INITR: begin
				cmd.mode = MODE_AXPY; cmd.src_a = VEC_B; cmd.src_b = VEC_Q;
				cmd.coef = ONE_Q; cmd.sub = 1'b1; cmd.dst = VEC_R;
			end
			S_INITP: begin
				cmd.mode = MODE_AXPY; cmd.src_a = VEC_R; cmd.src_b = VEC_R; cmd.dst = VEC_P;
			end
			S_RS0, S_RSN: begin cmd.mode = MODE_DOT; cmd.src_a = VEC_R; cmd.src_b = VEC_R; end
			S_MVP:   begin cmd.mode = MODE_MV; cmd.src_b = VEC_P; cmd.dst = VEC_Q; end
			S_DEN:   begin cmd.mode = MODE_DOT; cmd.src_a = VEC_P; cmd.src_b = VEC_Q; end
			S_UPX:   begin
				cmd.mode = MODE_AXPY; cmd.src_a = VEC_X; cmd.src_b = VEC_P;
				cmd.coef = alpha_q; cmd.dst = VEC_X;
			end
			S_UPR:   begin
				cmd.mode = MODE_AXPY; cmd.src_a = VEC_R; cmd.src_b = VEC_Q;
				cmd.coef = alpha_q; cmd.sub = 1'b1; cmd.dst = VEC_R;
			end
			S_UPP:   begin
				cmd.mode = MODE_AXPY; cmd.src_a = VEC_R; cmd.src_b = VEC_P;
				cmd.coef = beta_q; cmd.dst = VEC_P;
			end
			S_EMIT:  cmd.mode = MODE_OUT;
			default: pass_st = 1'b0;
		endcase
		go      = pass_st && !launched_q;
		div_go  = !launched_q && (state_q == S_ALPHA || (state_q == S_BETA && rs_q != 64'sd0));
		div_num = (state_q == S_ALPHA) ? rs_q : rsn_q;
		div_den = (state_q == S_ALPHA) ? den_q : rs_q;
	end

	cgs_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.go        (go),
		.cmd       (cmd),
		.n         (n_eff),
		.ld        (ld),
		.done      (eng_done),
		.dot_res   (dot_res),
		.out_valid (strobe),
		.out_data  (solution),
		.out_pos   (position),
		.out_last  (final_res)
	);

	cgs_qdiv u_qdiv (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (div_go),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			launched_q  <= 1'b0;
			conv_q      <= 1'b0;
			lc_q        <= '0;
			row_q       <= '0;
			col_q       <= '0;
			k_q         <= '0;
			prev_kind_q <= KIND_NONE;
			size_q      <= 5'd16;
			limit_q     <= 32'd1;
			iter_q      <= 10'd100;
			it_q        <= '0;
		end else begin
			if (go || div_go) launched_q <= 1'b1;
			if (cfg_valid) begin
				case (cfg_index)
					CFG_SIZE:  size_q  <= cfg_data[4:0];
					CFG_LIMIT: limit_q <= cfg_data;
					CFG_ITER:  iter_q  <= cfg_data[9:0];
					default:   ;
				endcase
			end
			unique case (state_q)
				S_IDLE: begin
					if (cfg_valid && cfg_index == CFG_SIZE) begin
						state_q <= S_REMAP;
						k_q     <= '0;
						row_q   <= '0;
						col_q   <= '0;
					end else if (ld.we) begin
						prev_kind_q <= kind;
						if (wrap) begin
							lc_q  <= '0;
							row_q <= '0;
							col_q <= '0;
						end else begin
							lc_q <= eff_lc + LC_W'(1);
							if (eff_col == LC_W'(n_eff) - LC_W'(1)) begin
								col_q <= '0;
								row_q <= eff_row + LC_W'(1);
							end else begin
								col_q <= eff_col + LC_W'(1);
								row_q <= eff_row;
							end
						end
						if (kind == KIND_GUESS && last) state_q <= S_MV0;
					end
				end
				S_REMAP: begin
					if (cfg_valid && cfg_index == CFG_SIZE) begin
						k_q   <= '0;
						row_q <= '0;
						col_q <= '0;
					end else if (k_q == lc_q) begin
						state_q <= S_IDLE;
					end else begin
						k_q <= k_q + LC_W'(1);
						if (col_q == LC_W'(n_eff) - LC_W'(1)) begin
							col_q <= '0;
							row_q <= row_q + LC_W'(1);
						end else begin
							col_q <= col_q + LC_W'(1);
						end
					end
				end
				S_ALPHA: begin
					if (div_done) begin
						alpha_q    <= quo;
						launched_q <= 1'b0;
						state_q    <= S_UPX;
					end
				end
				S_BETA: begin
					if (rs_q == 64'sd0) begin
						beta_q  <= '0;
						state_q <= S_UPP;
					end else if (div_done) begin
						beta_q     <= quo;
						launched_q <= 1'b0;
						state_q    <= S_UPP;
					end
				end
				default: begin
					if (eng_done) begin
						launched_q <= 1'b0;
						case (state_q)
							S_MV0:   state_q <= S_INITR;
							S_INITR: state_q <= S_INITP;
							S_INITP: state_q <= S_RS0;
							S_RS0: begin
								rs_q <= dot_res;
								it_q <= '0;
								if (iter_q == 10'd0) begin
									conv_q  <= 1'b0;
									state_q <= S_EMIT;
								end else begin
									state_q <= S_MVP;
								end
							end
							S_MVP:   state_q <= S_DEN;
							S_DEN: begin
								den_q <= dot_res;
								if (dot_res == 64'sd0) begin
									conv_q  <= 1'b0;
									state_q <= S_EMIT;
								end else begin
									state_q <= S_ALPHA;
								end
							end
							S_UPX:   state_q <= S_UPR;
							S_UPR:   state_q <= S_RSN;
							S_RSN: begin
								rsn_q <= dot_res;
								if (dot_res < $signed({32'd0, limit_q})) begin
									conv_q  <= 1'b1;
									state_q <= S_EMIT;
								end else begin
									state_q <= S_BETA;
								end
							end
							S_UPP: begin
								rs_q <= rsn_q;
								if (10'(it_q + 10'd1) == iter_q) begin
									conv_q  <= 1'b0;
									state_q <= S_EMIT;
								end else begin
									it_q    <= 10'(it_q + 10'd1);
									state_q <= S_MVP;
								end
							end
							default: begin
								state_q     <= S_IDLE;
								lc_q        <= '0;
								row_q       <= '0;
								col_q       <= '0;
								prev_kind_q <= KIND_NONE;
							end
						endcase
					end
				end
			endcase
		end
	end

	assign busy      = state_q != S_IDLE;
	assign converged = conv_q;
	assign cfg_ready = 1'b1;

endmodule

### src/cgs_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Conjugate gradient solver port checker
// Checks result sequencing and solve start as seen on the top-level ports.
// ----------------------------------------------------------------------------
module cgs_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic [1:0]         kind,
	input logic               last,
	input logic               strobe,
	input logic [3:0]         position,
	input logic               converged,
	input logic               final_res
);
	import cgs_pkg::*;

	a_result_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> busy)
		else $error("Result transfer while the solver is idle.");

	a_solve_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && kind == KIND_GUESS && last) |=> busy)
		else $error("Last guess element did not start a solve.");

	a_results_in_row: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && !final_res) |=> (strobe && position == 4'($past(position) + 4'd1)
			&& converged == $past(converged)))
		else $error("Result transfers are not consecutive.");

	a_run_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && final_res) |=> !strobe)
		else $error("Result transfer after the last element of a run.");

endmodule

bind conjugate_gradient_solver cgs_checker u_cgs_checker (.*);
